// File: sv/sem_pkg.sv
// Shared types, constants and helpers of the RGB Sobel edge magnitude unit.
// Used by every module of the block; depends on nothing else.
package sem_pkg;

  localparam int unsigned DEF_MAX_WIDTH  = 1024;
  localparam int unsigned DEF_MAX_HEIGHT = 1024;
  localparam int unsigned CFG_W          = 11;
  localparam int unsigned CH_W           = 8;
  localparam int unsigned PIX_W          = 3 * CH_W;
  localparam int unsigned FIFO_DEPTH     = 4;
  localparam logic [CFG_W-1:0] RESET_WIDTH  = 11'd640;
  localparam logic [CFG_W-1:0] RESET_HEIGHT = 11'd480;
  localparam logic [20:0]      CAP_LIMIT    = 21'd65280;
  localparam logic [CH_W-1:0]  CAP_VALUE    = 8'd255;

  typedef enum logic [1:0] {
    REG_WIDTH  = 2'd0,
    REG_HEIGHT = 2'd1
  } sem_reg_e;

  typedef enum logic [1:0] {
    F_IDLE,
    F_LOOK,
    F_TAIL
  } sem_front_e;

  typedef enum logic [2:0] {
    B_IDLE,
    B_GRAD,
    B_SQ,
    B_ROOT,
    B_FIN,
    B_PUSH
  } sem_back_e;

  // One result to compute: nine window pixels, index column * 3 + row
  // (columns left, middle, right; rows top, middle, bottom).
  typedef struct packed {
    logic [8:0][PIX_W-1:0] pix;
    logic                  run_last;
    logic                  frame_last;
  } sem_job_t;

  typedef struct packed {
    logic empty;
    logic full;
    logic room2;
  } sem_fifo_stat_t;

  // Channel k of a packed pixel: 0 red, 1 green, 2 blue.
  function automatic logic [CH_W-1:0] sem_chan(logic [PIX_W-1:0] p, int unsigned k);
    sem_chan = p[(2 - k) * CH_W +: CH_W];
  endfunction

endpackage

// File: sv/sem_fifo.sv
// Short job queue between the front and the back of the Sobel unit.
// Depends on sem_pkg.
module sem_fifo (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  sem_pkg::sem_job_t   job_i,
  input  logic                pop_i,
  output sem_pkg::sem_job_t   job_o,
  output sem_pkg::sem_fifo_stat_t stat_o
);
  import sem_pkg::*;

  localparam int unsigned PW = $clog2(FIFO_DEPTH);
  localparam int unsigned CW = $clog2(FIFO_DEPTH + 1);

  sem_job_t        buf_q [FIFO_DEPTH];
  logic [PW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [PW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]   cnt_q, cnt_d;

  always_comb begin
    wr_ptr_d = push_i ? wr_ptr_q + PW'(1) : wr_ptr_q;
    rd_ptr_d = pop_i ? rd_ptr_q + PW'(1) : rd_ptr_q;
    cnt_d    = cnt_q + CW'(push_i) - CW'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      buf_q[wr_ptr_q] <= job_i;
    end
  end

  assign job_o        = buf_q[rd_ptr_q];
  assign stat_o.empty = (cnt_q == '0);
  assign stat_o.full  = (cnt_q == CW'(FIFO_DEPTH));
  assign stat_o.room2 = (cnt_q <= CW'(FIFO_DEPTH - 2));

endmodule

// File: sv/sem_front.sv
// Front of the Sobel unit: accepts pixels, keeps the line store, the window
// and the raster counters, and queues one job per result. Depends on sem_pkg.
module sem_front #(
  parameter int unsigned MAX_WIDTH  = sem_pkg::DEF_MAX_WIDTH,
  parameter int unsigned MAX_HEIGHT = sem_pkg::DEF_MAX_HEIGHT
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [sem_pkg::CFG_W-1:0]   width_i,
  input  logic [sem_pkg::CFG_W-1:0]   height_i,
  input  logic                        valid_i,
  input  logic [sem_pkg::PIX_W-1:0]   pixel_i,
  input  logic                        drain_i,
  output logic                        ready_o,
  input  sem_pkg::sem_fifo_stat_t     stat_i,
  output logic                        push_o,
  output sem_pkg::sem_job_t           job_o
);
  import sem_pkg::*;

  localparam int unsigned IW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int unsigned EW = $clog2(MAX_WIDTH + 1);
  localparam int unsigned RW = $clog2(MAX_HEIGHT + 1);

  sem_front_e          state_q, state_d;
  logic [IW-1:0]       col_q, col_d;
  logic [RW-1:0]       row_q, row_d;
  logic [PIX_W-1:0]    win_q [6];
  logic [PIX_W-1:0]    win_d [6];
  logic [PIX_W-1:0]    pix_q;
  logic                drn_q;
  logic [2*PIX_W-1:0]  mem_q [MAX_WIDTH];
  logic [2*PIX_W-1:0]  rd_q;

  logic [EW-1:0]       w_eff;
  logic [RW-1:0]       h_eff;
  logic                accept;
  logic                last;
  logic                draining;
  logic                emitting;
  logic                has1, has2;
  logic [PIX_W-1:0]    cur [3];

  always_comb begin
    if (width_i == '0) begin
      w_eff = EW'(1);
    end else if (32'(width_i) > MAX_WIDTH) begin
      w_eff = EW'(MAX_WIDTH);
    end else begin
      w_eff = EW'(width_i);
    end
    if (height_i == '0) begin
      h_eff = RW'(1);
    end else if (32'(height_i) > MAX_HEIGHT) begin
      h_eff = RW'(MAX_HEIGHT);
    end else begin
      h_eff = RW'(height_i);
    end
  end

  assign accept   = valid_i && ready_o;
  assign draining = (row_q >= h_eff);
  assign last     = ((EW'(col_q) + EW'(1)) >= w_eff);
  assign emitting = (row_q != '0);
  assign has1     = (col_q != '0) && emitting;
  assign has2     = last && emitting;

  // Column of the current pixel: top, middle, bottom.
  always_comb begin
    cur[0] = (row_q > RW'(1)) ? rd_q[2*PIX_W-1:PIX_W] : '0;
    cur[1] = emitting ? rd_q[PIX_W-1:0] : '0;
    cur[2] = pix_q;
    for (int i = 0; i < 3; i++) begin
      win_d[i]     = (col_q == '0) ? '0 : win_q[i + 3];
      win_d[i + 3] = cur[i];
    end
    col_d = col_q;
    row_d = row_q;
    if (state_q == F_LOOK) begin
      if (last) begin
        col_d = '0;
        row_d = draining ? '0 : row_q + RW'(1);
      end else begin
        col_d = col_q + IW'(1);
      end
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      F_IDLE: begin
        if (accept) state_d = F_LOOK;
      end
      F_LOOK: begin
        state_d = has2 ? F_TAIL : F_IDLE;
      end
      F_TAIL: begin
        state_d = F_IDLE;
      end
      default: state_d = F_IDLE;
    endcase
  end

  always_comb begin
    ready_o = 1'b0;
    push_o  = 1'b0;
    job_o   = '0;
    case (state_q)
      F_IDLE: begin
        ready_o = stat_i.room2;
      end
      F_LOOK: begin
        push_o = has1;
        for (int i = 0; i < 3; i++) begin
          job_o.pix[i]     = win_q[i];
          job_o.pix[i + 3] = win_q[i + 3];
          job_o.pix[i + 6] = cur[i];
        end
        job_o.run_last = !has2;
      end
      F_TAIL: begin
        push_o = 1'b1;
        for (int i = 0; i < 6; i++) begin
          job_o.pix[i] = win_q[i];
        end
        job_o.run_last   = 1'b1;
        job_o.frame_last = drn_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
      col_q   <= '0;
      row_q   <= '0;
      for (int i = 0; i < 6; i++) begin
        win_q[i] <= '0;
      end
    end else begin
      state_q <= state_d;
      col_q   <= col_d;
      row_q   <= row_d;
      if (state_q == F_LOOK) begin
        for (int i = 0; i < 6; i++) begin
          win_q[i] <= win_d[i];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      pix_q <= (draining || drain_i) ? '0 : pixel_i;
      rd_q  <= mem_q[col_q];
    end
    if (state_q == F_LOOK) begin
      drn_q        <= draining;
      mem_q[col_q] <= {rd_q[PIX_W-1:0], pix_q};
    end
  end

endmodule

// File: sv/sem_back.sv
// Back of the Sobel unit: gradients, sum of squares, bit-serial rounded
// square root and the output register. Depends on sem_pkg.
module sem_back (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  sem_pkg::sem_fifo_stat_t     stat_i,
  input  sem_pkg::sem_job_t           job_i,
  output logic                        pop_o,
  output logic                        valid_o,
  input  logic                        ready_i,
  output logic [sem_pkg::PIX_W-1:0]   data_o,
  output logic                        last_o,
  output logic                        user_o
);
  import sem_pkg::*;

  sem_back_e         state_q, state_d;
  sem_job_t          job_q;
  logic [9:0]        ax_q [3];
  logic [9:0]        ay_q [3];
  logic [9:0]        ax_d [3];
  logic [9:0]        ay_d [3];
  logic [20:0]       s_q  [3];
  logic [20:0]       s_d  [3];
  logic [7:0]        n_q  [3];
  logic [7:0]        n_d  [3];
  logic [7:0]        res_q [3];
  logic [7:0]        res_d [3];
  logic [2:0]        bit_q;
  logic              out_v_q;
  logic [PIX_W-1:0]  out_data_q;
  logic              out_last_q, out_user_q;
  logic              load;

  always_comb begin
    logic signed [11:0] dx0, dx1, dx2, dy0, dy1, dy2, gx, gy;
    logic [19:0]        sqx, sqy;
    logic [7:0]         t;
    logic [15:0]        tt;
    logic [16:0]        nn;
    for (int k = 0; k < 3; k++) begin
      dx0 = $signed({4'b0, sem_chan(job_q.pix[6], k)}) - $signed({4'b0, sem_chan(job_q.pix[0], k)});
      dx1 = $signed({4'b0, sem_chan(job_q.pix[7], k)}) - $signed({4'b0, sem_chan(job_q.pix[1], k)});
      dx2 = $signed({4'b0, sem_chan(job_q.pix[8], k)}) - $signed({4'b0, sem_chan(job_q.pix[2], k)});
      dy0 = $signed({4'b0, sem_chan(job_q.pix[2], k)}) - $signed({4'b0, sem_chan(job_q.pix[0], k)});
      dy1 = $signed({4'b0, sem_chan(job_q.pix[5], k)}) - $signed({4'b0, sem_chan(job_q.pix[3], k)});
      dy2 = $signed({4'b0, sem_chan(job_q.pix[8], k)}) - $signed({4'b0, sem_chan(job_q.pix[6], k)});
      gx = dx0 + (dx1 <<< 1) + dx2;
      gy = dy0 + (dy1 <<< 1) + dy2;
      ax_d[k] = gx[11] ? 10'(-gx) : gx[9:0];
      ay_d[k] = gy[11] ? 10'(-gy) : gy[9:0];

      sqx = ax_q[k] * ax_q[k];
      sqy = ay_q[k] * ay_q[k];
      s_d[k] = {1'b0, sqx} + {1'b0, sqy};

      // One bit of the integer root per cycle, most significant first.
      t  = n_q[k] | (8'd1 << bit_q);
      tt = t * t;
      n_d[k] = ({5'b0, tt} <= s_q[k]) ? t : n_q[k];

      // Round to nearest: step up when s lies past n*n + n; a sum past CAP_LIMIT gives CAP_VALUE.
      nn = {1'b0, 16'(n_q[k]) * 16'(n_q[k])} + {9'b0, n_q[k]};
      if (s_q[k] > CAP_LIMIT) begin
        res_d[k] = CAP_VALUE;
      end else if (s_q[k] > {4'b0, nn}) begin
        res_d[k] = n_q[k] + 8'd1;
      end else begin
        res_d[k] = n_q[k];
      end
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      B_IDLE: if (!stat_i.empty) state_d = B_GRAD;
      B_GRAD: state_d = B_SQ;
      B_SQ:   state_d = B_ROOT;
      B_ROOT: if (bit_q == '0) state_d = B_FIN;
      B_FIN:  state_d = B_PUSH;
      B_PUSH: if (!out_v_q || ready_i) state_d = B_IDLE;
      default: state_d = B_IDLE;
    endcase
  end

  always_comb begin
    pop_o = 1'b0;
    load  = 1'b0;
    case (state_q)
      B_IDLE:  pop_o = !stat_i.empty;
      B_PUSH:  load  = !out_v_q || ready_i;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= B_IDLE;
      out_v_q <= 1'b0;
      bit_q   <= '0;
    end else begin
      state_q <= state_d;
      if (load) begin
        out_v_q <= 1'b1;
      end else if (ready_i) begin
        out_v_q <= 1'b0;
      end
      if (state_q == B_SQ) begin
        bit_q <= 3'd7;
      end else if (state_q == B_ROOT) begin
        bit_q <= bit_q - 3'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      job_q <= job_i;
    end
    for (int k = 0; k < 3; k++) begin
      case (state_q)
        B_GRAD: begin
          ax_q[k] <= ax_d[k];
          ay_q[k] <= ay_d[k];
        end
        B_SQ: begin
          s_q[k] <= s_d[k];
          n_q[k] <= '0;
        end
        B_ROOT: n_q[k] <= n_d[k];
        B_FIN:  res_q[k] <= res_d[k];
        default: ;
      endcase
    end
    if (load) begin
      out_data_q <= {res_q[2], res_q[1], res_q[0]};
      out_last_q <= job_q.run_last;
      out_user_q <= job_q.frame_last;
    end
  end

  assign valid_o = out_v_q;
  assign data_o  = out_data_q;
  assign last_o  = out_last_q;
  assign user_o  = out_user_q;

endmodule

// File: sv/sobel_edge_magnitude_rgb_unit.sv
// Flow: an accepted pixel is read from the line store into a register on the
// accepting edge; the front forms its jobs in F_LOOK (and F_TAIL for a row-end
// pixel), and the back takes each job through B_GRAD, B_SQ, B_ROOT, B_FIN and
// B_PUSH. The front takes no new pixel until the jobs of the last are queued;
// the back finishes one job before it pops the next. Reset clears counters,
// window and queue; the line store needs no clearing pass.
// Top level of the RGB Sobel edge magnitude unit.
// Depends on sem_pkg, sem_front, sem_fifo and sem_back.
module sobel_edge_magnitude_rgb_unit #(
  parameter int unsigned MAX_WIDTH  = sem_pkg::DEF_MAX_WIDTH,
  parameter int unsigned MAX_HEIGHT = sem_pkg::DEF_MAX_HEIGHT
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // Pixel stream in.
  input  logic                       s_axis_tvalid,
  output logic                       s_axis_tready,
  input  logic [23:0]                s_axis_tdata,  // in_red, in_green, in_blue
  input  logic                       s_axis_tuser,  // drain
  // Result stream out.
  output logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  output logic [23:0]                m_axis_tdata,  // out_red, out_green, out_blue
  output logic                       m_axis_tlast,  // run_last
  output logic                       m_axis_tuser,  // frame_last
  // Register write request.
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [1:0]                 cfg_index_i,
  input  logic [sem_pkg::CFG_W-1:0]  cfg_data_i
);
  import sem_pkg::*;

  logic [CFG_W-1:0] width_q, height_q;
  logic             push, pop;
  sem_job_t         push_job, pop_job;
  sem_fifo_stat_t   fstat;
  logic [23:0]      res_data;

  // Registers take a write request at any time; the host only writes them
  // while the block is idle.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= RESET_WIDTH;
      height_q <= RESET_HEIGHT;
    end else if (cfg_valid_i) begin
      case (sem_reg_e'(cfg_index_i))
        REG_WIDTH:  width_q  <= cfg_data_i;
        REG_HEIGHT: height_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // The front packs pixels red high, blue low; the stream puts red lowest.
  sem_front #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT)
  ) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .width_i (width_q),
    .height_i(height_q),
    .valid_i (s_axis_tvalid),
    .pixel_i ({s_axis_tdata[7:0], s_axis_tdata[15:8], s_axis_tdata[23:16]}),
    .drain_i (s_axis_tuser),
    .ready_o (s_axis_tready),
    .stat_i  (fstat),
    .push_o  (push),
    .job_o   (push_job)
  );

  sem_fifo u_fifo (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .push_i(push),
    .job_i (push_job),
    .pop_i (pop),
    .job_o (pop_job),
    .stat_o(fstat)
  );

  sem_back u_back (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .stat_i (fstat),
    .job_i  (pop_job),
    .pop_o  (pop),
    .valid_o(m_axis_tvalid),
    .ready_i(m_axis_tready),
    .data_o (res_data),
    .last_o (m_axis_tlast),
    .user_o (m_axis_tuser)
  );

  // The back delivers channel 0 (red) in its low byte already.
  assign m_axis_tdata = res_data;

  // The front only offers a pixel when the queue can take both its jobs.
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> !fstat.full)
    else $error("job queue overflow");

  // One pixel at a time: the front is busy right after it accepts a pixel.
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("front accepted a pixel while busy");

  // The bottom-right result is always the last one of its pixel.
  a_frame_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tlast)
    else $error("frame end without run end");

endmodule
